FILE: design/crc_pkg.sv
// circle raster canvas package: word structs, mode and register codes, fsm states
// no dependencies
`default_nettype none
package crc_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_FILLED  = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [19:0] ctr_col;
    logic signed [19:0] ctr_row;
    logic        [19:0] radius;
    logic        [7:0]  color;
    logic        [7:0]  pixel_x;
    logic        [7:0]  pixel_y;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic [7:0] pixel_value;
  } out_word_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam int SQ_W  = 20;
  localparam int SQ_CW = 5;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SETUP = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

FILE: design/crc_sq.sv
// serial shift-add squarer, one multiplier bit per cycle
// depends on crc_pkg
`default_nettype none
module crc_sq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          sq_start,
  input  wire logic [crc_pkg::SQ_W-1:0]      sq_op,
  output logic                               sq_done,
  output logic      [2*crc_pkg::SQ_W-1:0]    sq_res
);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [crc_pkg::SQ_CW-1:0]     cnt_r, cnt_nxt;
  logic [2*crc_pkg::SQ_W-1:0]    a_r, a_nxt;
  logic [crc_pkg::SQ_W-1:0]      b_r, b_nxt;
  logic [2*crc_pkg::SQ_W-1:0]    acc_r, acc_nxt;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (sq_start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      a_nxt   = (2*crc_pkg::SQ_W)'(sq_op);
      b_nxt   = sq_op;
      acc_nxt = '0;
    end else if (run_r) begin
      acc_nxt = acc_r + (b_r[0] ? a_r : '0);
      a_nxt   = {a_r[2*crc_pkg::SQ_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[crc_pkg::SQ_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == crc_pkg::SQ_CW'(crc_pkg::SQ_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign sq_done = done_r;
  assign sq_res  = acc_r;

endmodule
`default_nettype wire

FILE: design/circle_raster_canvas.sv
// circle raster canvas top level: canvas memory, scan sequencer, config registers
// depends on crc_pkg and crc_sq
//
// usage: present a word on in_data with start high; it is taken at an edge where busy
// is low. busy drops in the cycle in which the one result word is on out_data with
// out_valid high for a single cycle; the receiver cannot stall and must take it then.
// a new word can be taken in that same cycle, so one word is in flight at a time
// config words (cfg_index, cfg_data) are taken whenever cfg_valid is high; write them
// only while busy is low and no result is pending
// latency per word, from the accepting edge to the edge that takes the result:
//   read: 2 cycles (one registered read of the canvas memory)
//   clear: one cycle per memory cell, 4**ceil(log2(MAX_SIDE)) cells (at least 4),
//     plus 1
//   circle: 1 + 4 * 22 cycles of setup in the shared serial squarer, then one
//     cycle per pixel of the width x height rectangle; the memory write port
//     paints at most one pixel per cycle
//   zero radius, or zero width or height: 1 cycle, busy stays low
// reset restores width 256, height 256, background 32 and leaves the canvas
// contents undefined until a clear or a circle writes them.
`default_nettype none
module circle_raster_canvas #(
  parameter int MAX_SIDE = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire crc_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output crc_pkg::out_word_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data
);

  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = 2 * XW;
  localparam int DEPTH = 1 << AW;

  function automatic logic [40:0] sq_step(input logic signed [20:0] d);
    return {{11{d[20]}}, d, 9'd0} + 41'd65536;
  endfunction

  function automatic logic [19:0] mag20(input logic signed [20:0] v);
    logic signed [20:0] n;
    n = -v;
    return v[20] ? n[19:0] : v[19:0];
  endfunction

  crc_pkg::state_t     state_r, state_nxt;
  crc_pkg::in_word_t   item_r, item_nxt;
  crc_pkg::out_word_t  out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [8:0]          cw_r, cw_nxt, ch_r, ch_nxt;
  logic [7:0]          bg_r, bg_nxt;
  logic [SW-1:0]       w_r, w_nxt, h_r, h_nxt;
  logic [SW-1:0]       x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [40:0]         dx2_r, dx2_nxt, dy2_r, dy2_nxt;
  logic [39:0]         cx2_r, cx2_nxt, cy2_r, cy2_nxt, r2_r, r2_nxt, in2_r, in2_nxt;
  logic [1:0]          sel_r, sel_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                inrng_r, inrng_nxt;
  logic [7:0]          rd_q_r;

  logic [7:0]          mem [DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [7:0]          mem_wd;

  logic                accept;
  logic [SW-1:0]       w_eff, h_eff;
  logic signed [20:0]  cx_ext, cy_ext, ncx, ncy, inner;
  logic                sq_start, sq_done;
  logic [19:0]         sq_op;
  logic [39:0]         sq_res;
  logic [40:0]         d2;
  logic                hit, in_ring;

  assign accept    = start && !busy;
  assign busy      = (state_r != crc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign w_eff = (32'(cw_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(cw_r);
  assign h_eff = (32'(ch_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(ch_r);

  assign cx_ext = $signed({item_r.ctr_col[19], item_r.ctr_col});
  assign cy_ext = $signed({item_r.ctr_row[19], item_r.ctr_row});
  assign ncx    = -cx_ext;
  assign ncy    = -cy_ext;
  assign inner  = $signed({1'b0, item_r.radius}) - 21'sd256;

  always_comb begin
    unique case (sel_r)
      2'd0:    sq_op = mag20(cx_ext);
      2'd1:    sq_op = mag20(cy_ext);
      2'd2:    sq_op = item_r.radius;
      default: sq_op = mag20(inner);
    endcase
  end

  assign sq_start = (state_r == crc_pkg::ST_SETUP) && !pend_r;

  crc_sq u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_start (sq_start),
    .sq_op    (sq_op),
    .sq_done  (sq_done),
    .sq_res   (sq_res)
  );

  assign d2      = dx2_r + dy2_r;
  assign in_ring = (item_r.mode == crc_pkg::MODE_OUTLINE) && (|item_r.radius[19:8])
                   && (d2 <= {1'b0, in2_r});
  assign hit     = (d2 <= {1'b0, r2_r}) && !in_ring;

  assign mem_ra = {XW'(in_data.pixel_y), XW'(in_data.pixel_x)};

  always_comb begin
    cw_nxt = cw_r;
    ch_nxt = ch_r;
    bg_nxt = bg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crc_pkg::CFG_WIDTH:  cw_nxt = cfg_data;
        crc_pkg::CFG_HEIGHT: ch_nxt = cfg_data;
        crc_pkg::CFG_BG:     bg_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    cx2_nxt       = cx2_r;
    cy2_nxt       = cy2_r;
    r2_nxt        = r2_r;
    in2_nxt       = in2_r;
    sel_nxt       = sel_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    inrng_nxt     = inrng_r;
    mem_we        = 1'b0;
    mem_wa        = {y_r[XW-1:0], x_r[XW-1:0]};
    mem_wd        = item_r.color;

    unique case (state_r)
      crc_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          w_nxt    = w_eff;
          h_nxt    = h_eff;
          unique case (in_data.mode)
            crc_pkg::MODE_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = crc_pkg::ST_CLEAR;
            end
            crc_pkg::MODE_READ: begin
              inrng_nxt = (32'(in_data.pixel_x) < MAX_SIDE) &&
                          (32'(in_data.pixel_y) < MAX_SIDE);
              state_nxt = crc_pkg::ST_READ;
            end
            default: begin
              if (in_data.radius == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: crc_pkg::STATUS_REJECT, pixel_value: 8'd0};
              end else if (w_eff == '0 || h_eff == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: crc_pkg::STATUS_DONE, pixel_value: 8'd0};
              end else begin
                sel_nxt   = 2'd0;
                pend_nxt  = 1'b0;
                state_nxt = crc_pkg::ST_SETUP;
              end
            end
          endcase
        end
      end

      crc_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = bg_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: crc_pkg::STATUS_DONE, pixel_value: 8'd0};
          state_nxt     = crc_pkg::ST_IDLE;
        end
      end

      crc_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: crc_pkg::STATUS_DONE,
                          pixel_value: inrng_r ? rd_q_r : 8'd0};
        state_nxt     = crc_pkg::ST_IDLE;
      end

      crc_pkg::ST_SETUP: begin
        if (sq_start) begin
          pend_nxt = 1'b1;
        end else if (sq_done) begin
          pend_nxt = 1'b0;
          sel_nxt  = sel_r + 1'b1;
          unique case (sel_r)
            2'd0: cx2_nxt = sq_res;
            2'd1: cy2_nxt = sq_res;
            2'd2: r2_nxt  = sq_res;
            default: begin
              in2_nxt   = sq_res;
              x_nxt     = '0;
              y_nxt     = '0;
              dx_nxt    = ncx;
              dy_nxt    = ncy;
              dx2_nxt   = {1'b0, cx2_r};
              dy2_nxt   = {1'b0, cy2_r};
              state_nxt = crc_pkg::ST_SCAN;
            end
          endcase
        end
      end

      crc_pkg::ST_SCAN: begin
        mem_we = hit;
        if (x_r == SW'(w_r - SW'(1))) begin
          x_nxt   = '0;
          dx_nxt  = ncx;
          dx2_nxt = {1'b0, cx2_r};
          if (y_r == SW'(h_r - SW'(1))) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: crc_pkg::STATUS_DONE, pixel_value: 8'd0};
            state_nxt     = crc_pkg::ST_IDLE;
          end else begin
            y_nxt   = y_r + 1'b1;
            dy_nxt  = dy_r + 21'sd256;
            dy2_nxt = dy2_r + sq_step(dy_r);
          end
        end else begin
          x_nxt   = x_r + 1'b1;
          dx_nxt  = dx_r + 21'sd256;
          dx2_nxt = dx2_r + sq_step(dx_r);
        end
      end

      default: state_nxt = crc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cw_r        <= 9'd256;
      ch_r        <= 9'd256;
      bg_r        <= 8'd32;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cw_r        <= cw_nxt;
      ch_r        <= ch_nxt;
      bg_r        <= bg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dx2_r      <= dx2_nxt;
    dy2_r      <= dy2_nxt;
    cx2_r      <= cx2_nxt;
    cy2_r      <= cy2_nxt;
    r2_r       <= r2_nxt;
    in2_r      <= in2_nxt;
    sel_r      <= sel_nxt;
    clr_r      <= clr_nxt;
    inrng_r    <= inrng_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[mem_ra];
  end

endmodule
`default_nettype wire

FILE: bench/tb_circle_raster_canvas.sv
// testbench for circle_raster_canvas: directed and random words, each result word
// checked against a behavioral canvas painter kept inside the bench
// depends on crc_pkg and the circle_raster_canvas rtl
module tb_circle_raster_canvas;

  localparam int SIDE = 256;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    crc_pkg::out_word_t word;
    int                 seq;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  crc_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  crc_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [8:0]         cfg_data = '0;

  logic [7:0] canvas_mem [SIDE*SIDE];
  logic [8:0] cols_reg = 9'd256;
  logic [8:0] rows_reg = 9'd256;
  logic [7:0] bg_reg = 8'd32;
  pending_t   pending_results[$];
  pending_t   head;

  int send_idle_pct = 0;
  int words_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int reg_writes = 0;
  int clears_sent = 0;
  int circles_sent = 0;
  int rejects_sent = 0;
  int reads_sent = 0;

  circle_raster_canvas #(
    .MAX_SIDE(SIDE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int seq, input logic [8:0] got,
                                 input logic [8:0] want);
    $display("mismatch: word %0d %s got 0x%0h want 0x%0h", seq, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", -1, 9'(out_data), '0);
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== head.word.status)
          report_mismatch("status", head.seq, 9'(out_data.status), 9'(head.word.status));
        if (out_data.pixel_value !== head.word.pixel_value)
          report_mismatch("pixel_value", head.seq, 9'(out_data.pixel_value),
                          9'(head.word.pixel_value));
      end
    end
  end

  function automatic int clamp_side(input logic [8:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  // paints the bench canvas for one word and gives the result word it should produce
  task automatic raster_word(input crc_pkg::in_word_t w, output crc_pkg::out_word_t res);
    int     cols, rows;
    longint cx, cy, r, r2, inner, inner2, dx, dy, d2;
    logic   hit;
    cols = clamp_side(cols_reg);
    rows = clamp_side(rows_reg);
    cx = longint'(signed'(w.ctr_col));
    cy = longint'(signed'(w.ctr_row));
    r = longint'({44'd0, w.radius});
    r2 = r * r;
    inner = r - 256;
    inner2 = inner * inner;
    res.status = crc_pkg::STATUS_DONE;
    res.pixel_value = '0;
    case (w.mode)
      crc_pkg::MODE_CLEAR: begin
        foreach (canvas_mem[i]) canvas_mem[i] = bg_reg;
      end
      crc_pkg::MODE_READ: begin
        res.pixel_value = canvas_mem[{w.pixel_y, w.pixel_x}];
      end
      default: begin
        if (w.radius == '0) begin
          res.status = crc_pkg::STATUS_REJECT;
        end else begin
          for (int y = 0; y < rows; y++) begin
            dy = longint'(y) * 256 - cy;
            for (int x = 0; x < cols; x++) begin
              dx = longint'(x) * 256 - cx;
              d2 = dx * dx + dy * dy;
              hit = (d2 <= r2);
              if (hit && w.mode == crc_pkg::MODE_OUTLINE && inner >= 0) hit = (d2 > inner2);
              if (hit) canvas_mem[y * SIDE + x] = w.color;
            end
          end
        end
      end
    endcase
  endtask

  task automatic send_word(input crc_pkg::in_word_t w);
    int                 gap;
    crc_pkg::out_word_t res;
    pending_t           p;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    raster_word(w, res);
    p.word = res;
    p.seq = words_sent;
    pending_results.push_back(p);
    words_sent++;
    case (w.mode)
      crc_pkg::MODE_CLEAR: clears_sent++;
      crc_pkg::MODE_READ:  reads_sent++;
      default: begin
        circles_sent++;
        if (res.status == crc_pkg::STATUS_REJECT) rejects_sent++;
      end
    endcase
  endtask

  task automatic wait_drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crc_pkg::CFG_WIDTH:  cols_reg = val;
      crc_pkg::CFG_HEIGHT: rows_reg = val;
      crc_pkg::CFG_BG:     bg_reg = val[7:0];
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_canvas(input logic [8:0] cols, input logic [8:0] rows,
                            input logic [8:0] bg);
    wait_drain();
    cfg_write(crc_pkg::CFG_WIDTH, cols, 1'b0);
    cfg_write(crc_pkg::CFG_HEIGHT, rows, 1'b0);
    cfg_write(crc_pkg::CFG_BG, bg, 1'b1);
  endtask

  function automatic crc_pkg::in_word_t random_word();
    crc_pkg::in_word_t w;
    logic [31:0]       a, b, c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    w.mode = crc_pkg::mode_t'(a[1:0]);
    w.ctr_col = a[31:12];
    w.ctr_row = b[19:0];
    w.radius = c[19:0];
    w.color = b[27:20];
    w.pixel_x = c[27:20];
    w.pixel_y = {a[11:8], b[31:28]};
    return w;
  endfunction

  function automatic crc_pkg::in_word_t make_clear();
    crc_pkg::in_word_t w;
    w = random_word();
    w.mode = crc_pkg::MODE_CLEAR;
    return w;
  endfunction

  function automatic crc_pkg::in_word_t make_read(input int px, input int py);
    crc_pkg::in_word_t w;
    w = random_word();
    w.mode = crc_pkg::MODE_READ;
    w.pixel_x = px[7:0];
    w.pixel_y = py[7:0];
    return w;
  endfunction

  function automatic crc_pkg::in_word_t make_circle(input crc_pkg::mode_t m, input int cx,
                                                    input int cy, input int r,
                                                    input logic [7:0] color);
    crc_pkg::in_word_t w;
    w = random_word();
    w.mode = m;
    w.ctr_col = cx[19:0];
    w.ctr_row = cy[19:0];
    w.radius = r[19:0];
    w.color = color;
    return w;
  endfunction

  function automatic crc_pkg::in_word_t random_item();
    crc_pkg::in_word_t w;
    int                cols, rows, span, roll, cx, cy, r, px, py;
    w = random_word();
    cols = clamp_side(cols_reg);
    rows = clamp_side(rows_reg);
    span = (cols > rows) ? cols : rows;
    if (span < 1) span = 1;
    roll = $urandom_range(99);
    if (roll < 3) begin
      w.mode = crc_pkg::MODE_CLEAR;
    end else if (roll < 38) begin
      w.mode = crc_pkg::MODE_READ;
      if (cols > 0 && rows > 0 && $urandom_range(9) < 7) begin
        px = $urandom_range(cols - 1);
        py = $urandom_range(rows - 1);
        w.pixel_x = px[7:0];
        w.pixel_y = py[7:0];
      end
    end else begin
      w.mode = ($urandom_range(1) == 0) ? crc_pkg::MODE_OUTLINE : crc_pkg::MODE_FILLED;
      // most circles sit on or near the rectangle in use; the rest keep raw fields
      if (roll >= 46) begin
        cx = $urandom_range((cols + 4) * 256);
        cy = $urandom_range((rows + 4) * 256);
        cx = cx - 512;
        cy = cy - 512;
        r = $urandom_range(span * 256 + 256, 1);
        if ($urandom_range(19) == 0) r = 0;
        w.ctr_col = cx[19:0];
        w.ctr_row = cy[19:0];
        w.radius = r[19:0];
      end
    end
    return w;
  endfunction

  task automatic pick_canvas;
    int          roll, c, r;
    logic [31:0] v;
    roll = $urandom_range(9);
    c = $urandom_range(20, 1);
    r = $urandom_range(20, 1);
    case (roll)
      0: c = 0;
      1: r = 0;
      2: begin
        c = $urandom_range(511, 256);
        r = $urandom_range(2, 1);
      end
      3: begin
        c = $urandom_range(2, 1);
        r = $urandom_range(511, 256);
      end
      default: ;
    endcase
    v = $urandom;
    set_canvas(c[8:0], r[8:0], v[8:0]);
  endtask

  task automatic test_clear_then_read;
    send_word(make_clear());
    send_word(make_read(0, 0));
    send_word(make_read(255, 255));
  endtask

  task automatic test_full_canvas;
    send_word(make_circle(crc_pkg::MODE_FILLED, 128 * 256 + 128, 100 * 256, 40 * 256 + 77,
                          8'hA5));
    send_word(make_read(128, 100));
    send_word(make_read(168, 100));
  endtask

  task automatic test_register_extremes;
    logic [31:0] v;
    v = $urandom;
    wait_drain();
    cfg_write(CFG_UNUSED, v[8:0], 1'b0);
    set_canvas(9'd511, 9'd1, 9'h1C3);
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 200 * 256 + 128, 0, 30 * 256, 8'h3C));
    send_word(make_read(230, 0));
    set_canvas(9'd0, 9'd5, 9'h1C3);
    send_word(make_circle(crc_pkg::MODE_FILLED, 0, 0, 1048575, 8'h11));
    set_canvas(9'd5, 9'd0, 9'h1C3);
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 0, 0, 1048575, 8'h22));
    set_canvas(9'd3, 9'd511, 9'h0FF);
    send_word(make_circle(crc_pkg::MODE_FILLED, 256, 128 * 256, 50 * 256, 8'h5E));
    send_word(make_read(2, 170));
    send_word(make_clear());
    send_word(make_read(77, 201));
  endtask

  task automatic test_radius_edges;
    set_canvas(9'd16, 9'd16, 9'h05A);
    send_word(make_circle(crc_pkg::MODE_FILLED, 3 * 256, 3 * 256, 0, 8'hEE));
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 7 * 256, 7 * 256, 0, 8'hEE));
    // outline below one pixel paints the whole disc
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 5 * 256, 5 * 256, 128, 8'h81));
    send_word(make_read(5, 5));
    // outline of exactly one pixel skips the center
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 9 * 256, 9 * 256, 256, 8'h42));
    send_word(make_read(9, 9));
    send_word(make_read(10, 9));
    send_word(make_circle(crc_pkg::MODE_FILLED, -524288, 524287, 1048575, 8'hC7));
    send_word(make_read(0, 15));
    send_word(make_circle(crc_pkg::MODE_OUTLINE, 8 * 256, 8 * 256, 1048575, 8'h18));
    send_word(make_circle(crc_pkg::MODE_FILLED, 3 * 256, 3 * 256, 1, 8'h99));
    send_word(make_read(3, 3));
  endtask

  task automatic test_random_words(input int idle_pct, input int count);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0) pick_canvas();
      send_word(random_item());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_clear_then_read();
    test_full_canvas();
    test_register_extremes();
    test_radius_edges();
    test_random_words(27, 25);
    test_random_words(82, 25);
    test_random_words(0, 24);
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d words sent (%0d clears, %0d circles with %0d zero radius, %0d reads)",
             words_sent, clears_sent, circles_sent, rejects_sent, reads_sent);
    $display("summary: %0d register writes, %0d results checked, %0d mismatches",
             reg_writes, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
